[hw/rtl/d2m_pkg.sv]
// Package: shared types, constants and status codes for the double to 1750A converter.
`timescale 1ns / 1ps
package d2m_pkg;
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADFMT = 2'd1,
    ST_INFNAN = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    FMT_16  = 2'd0,
    FMT_32  = 2'd1,
    FMT_48  = 2'd2,
    FMT_BAD = 2'd3
  } fmt_t;

  localparam int FRAC_BITS = 52;
  localparam int SIG_BITS  = 53;
  localparam int WORD_BITS = 48;
  localparam int EXP_W     = 12;   // signed working exponent

  typedef struct packed {
    logic           kind;
    logic [63:0]    double_bits;
    logic [1:0]     format_select;
  } d2m_in_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] result_word;
    logic [1:0]           status;
  } d2m_out_t;
endpackage

[hw/rtl/d2m_if.sv]
// Interface: valid/ready channel carrying one payload.
`timescale 1ns / 1ps
interface d2m_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/d2m_norm.sv]
// Normalizer: unpacks a binary64 into a 53-bit significand and signed exponent.
`timescale 1ns / 1ps
module d2m_norm import d2m_pkg::*; (
  input  logic [63:0]                dbl,
  output logic [SIG_BITS-1:0]        sig,
  output logic signed [EXP_W-1:0]    expo
);
  logic [10:0] efield;
  logic [FRAC_BITS-1:0] frac;
  logic [5:0] lz;
  logic found;

  assign efield = dbl[62:52];
  assign frac   = dbl[FRAC_BITS-1:0];

  // leading zero count over the fraction for subnormals
  always_comb begin
    lz = 6'd0;
    found = 1'b0;
    for (int i = FRAC_BITS - 1; i >= 0; i--) begin
      if (!found && frac[i]) begin
        found = 1'b1;
        lz = 6'(FRAC_BITS - 1 - i);
      end
    end
  end

  always_comb begin
    if (efield != 11'd0) begin
      sig  = {1'b1, frac};
      expo = $signed({1'b0, efield}) - EXP_W'(1022);
    end else begin
      // top bit at position p = 51 - lz, shifted up by 52 - p = lz + 1
      sig  = {1'b0, frac} << (lz + 6'd1);
      expo = EXP_W'(-1022) - $signed({6'd0, lz});
    end
  end
endmodule

[hw/rtl/double_to_mil1750a_float.sv]
// Top level: IEEE double to MIL-STD-1750A float converter.
//
//  channel  | dir | payload                              | transfer
//  in_ch    | in  | kind, double_bits, format_select     | valid & ready
//  out_ch   | out | result_word, status                  | valid & ready
//
// One item per cycle sustained unless the output stalls; input register, then
// result register. Path: normalize with one leading-zero count, round, negate.
// rst clears both valid bits; payload registers are not reset.
// A stalled output holds the result; the input register advances whenever the
// result register is free or drains in the same cycle.
`timescale 1ns / 1ps
module double_to_mil1750a_float import d2m_pkg::*; (
  input logic clk,
  input logic rst,
  d2m_if.sink   in_ch,
  d2m_if.source out_ch
);
  d2m_in_t  in_reg;
  logic     in_vld;
  d2m_out_t out_reg;
  logic     out_vld;
  d2m_out_t res_next;
  logic     advance;

  assign advance      = in_vld && (!out_vld || out_ch.ready);
  assign in_ch.ready  = !in_vld || advance;
  assign out_ch.valid = out_vld;
  assign out_ch.payload = out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      if (in_ch.ready) in_vld <= in_ch.valid;
      if (advance) out_vld <= 1'b1;
      else if (out_ch.ready) out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) in_reg <= in_ch.payload;
    if (advance) out_reg <= res_next;
  end

  // datapath
  logic [SIG_BITS-1:0]     sig;
  logic signed [EXP_W-1:0] e0, e1, e2, ehi, elo, ec;
  logic [40:0]             mt;
  logic [39:0]             m1, mn, m2, mask, top2;
  logic                    neg;
  logic [1:0]              fsel;
  logic [5:0]              w;

  d2m_norm u_norm (.dbl(in_reg.double_bits), .sig(sig), .expo(e0));

  assign fsel = in_reg.format_select;
  assign neg  = in_reg.double_bits[63];

  always_comb begin
    case (fsel)
      FMT_16: begin
        w = 6'd10; ehi = EXP_W'(31); elo = EXP_W'(-32);
        mt = 41'(sig[52:43]); mask = 40'h3FF; top2 = 40'h300;
      end
      FMT_32: begin
        w = 6'd24; ehi = EXP_W'(127); elo = EXP_W'(-128);
        mt = 41'(sig[52:29]); mask = 40'hFF_FFFF; top2 = 40'hC0_0000;
      end
      default: begin
        w = 6'd40; ehi = EXP_W'(127); elo = EXP_W'(-128);
        mt = 41'(sig[52:13]); mask = 40'hFF_FFFF_FFFF; top2 = 40'hC0_0000_0000;
      end
    endcase
    // round half up on last bit, drop it
    mt = (mt + 41'(mt[0])) >> 1;
    e1 = e0;
    m1 = mt[39:0];
    if (|(mt[39:0] & ~(mask >> 1))) begin
      m1 = mt[39:0] >> 1;
      e1 = e0 + EXP_W'(1);
    end
    m2 = m1;
    e2 = e1;
    mn = (~m1 + 40'd1) & mask;
    if (neg) begin
      m2 = mn;
      if ((mn & top2) == top2) begin
        m2 = (mn << 1) & mask;
        e2 = e1 - EXP_W'(1);
      end
    end
    if (e2 > ehi) ec = ehi;
    else if (e2 < elo) ec = elo;
    else ec = e2;

    res_next.status = ST_OK;
    res_next.result_word = '0;
    if (fsel == FMT_BAD) begin
      res_next.status = ST_BADFMT;
    end else if (in_reg.double_bits[62:52] == 11'h7FF) begin
      res_next.status = ST_INFNAN;
    end else if (in_reg.double_bits[62:0] == 63'd0) begin
      res_next.result_word = '0;
    end else begin
      case (fsel)
        FMT_16:  res_next.result_word = {32'd0, m2[9:0], ec[5:0]};
        FMT_32:  res_next.result_word = {16'd0, m2[23:0], ec[7:0]};
        default: res_next.result_word = {m2[39:16], ec[7:0], m2[15:0]};
      endcase
    end
  end

  logic unused_kind;
  assign unused_kind = in_reg.kind ^ (w == 6'd0);
endmodule

[hw/rtl/d2m_checker.sv]
// Checker: port-level assertions for the converter, bound to the top level.
`timescale 1ns / 1ps
module d2m_props import d2m_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input d2m_out_t out_payload
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("output changed while stalled");
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_payload.status == ST_OK || out_payload.status == ST_BADFMT
                  || out_payload.status == ST_INFNAN)
    else $error("bad status code");
  a_errzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_payload.status != ST_OK |-> out_payload.result_word == '0)
    else $error("error result not zero");
  a_produce: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> ##1 out_valid)
    else $error("accepted item gave no result");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");
endmodule

bind double_to_mil1750a_float d2m_props u_chk (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_payload(out_ch.payload)
);

[dv/d2m_checker.sv]
// Checker: predicts each 1750A conversion and compares the results in order.
`timescale 1ns / 1ps
module d2m_checker import d2m_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_ready,
  input  d2m_in_t  in_item,
  input  logic     out_valid,
  input  logic     out_ready,
  input  d2m_out_t out_item,
  output int       fail_count,
  output int       pending
);
  d2m_out_t conversions_due[$];

  // Compute the 1750A word and status for one input item.
  function automatic d2m_out_t convert(d2m_in_t it);
    d2m_out_t r;
    logic [10:0] ef;
    logic [51:0] fr;
    logic [63:0] sig, m, mask, eb;
    int e, w, elo, ehi, p;
    ef = it.double_bits[62:52];
    fr = it.double_bits[51:0];
    r.result_word = '0;
    r.status = ST_OK;
    if (fmt_t'(it.format_select) == FMT_BAD) begin
      r.status = ST_BADFMT;
      return r;
    end
    if (ef == 11'h7FF) begin
      r.status = ST_INFNAN;
      return r;
    end
    if (ef == 0 && fr == 0) return r;
    if (ef != 0) begin
      sig = {11'd0, 1'b1, fr};
      e = int'(ef) - 1022;
    end else begin
      p = 0;
      for (int i = 0; i < 52; i++) if (fr[i]) p = i;
      sig = {12'd0, fr} << (52 - p);
      e = p - 1073;
    end
    case (fmt_t'(it.format_select))
      FMT_16: begin w = 10; elo = -32; ehi = 31; end
      FMT_32: begin w = 24; elo = -128; ehi = 127; end
      default: begin w = 40; elo = -128; ehi = 127; end
    endcase
    mask = (64'd1 << w) - 1;
    m = sig >> (53 - w);
    if (m[0]) m++;
    m = m >> 1;
    if (m[w-1]) begin
      m = m >> 1;
      e++;
    end
    if (it.double_bits[63]) begin
      m = (~m + 1) & mask;
      if (((m >> (w - 2)) & 3) == 3) begin
        m = (m << 1) & mask;
        e--;
      end
    end
    if (e > ehi) e = ehi;
    else if (e < elo) e = elo;
    eb = 64'(signed'(e));
    case (fmt_t'(it.format_select))
      FMT_16: r.result_word = 48'(((m & mask) << 6) | (eb & 64'h3F));
      FMT_32: r.result_word = 48'(((m & mask) << 8) | (eb & 64'hFF));
      default: r.result_word = 48'((((m >> 16) & 64'hFFFFFF) << 24)
                                   | ((eb & 64'hFF) << 16) | (m & 64'hFFFF));
    endcase
    return r;
  endfunction

  task automatic report(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending = conversions_due.size();

  always @(posedge clk) begin
    d2m_out_t want;
    if (!rst) begin
      if (in_valid && in_ready) conversions_due.push_back(convert(in_item));
      if (out_valid && out_ready) begin
        if (conversions_due.size() == 0) begin
          report("result transfer with nothing outstanding");
        end else begin
          want = conversions_due.pop_front();
          if (out_item.result_word !== want.result_word)
            report($sformatf("result_word %h, want %h", out_item.result_word,
                             want.result_word));
          if (out_item.status !== want.status)
            report($sformatf("status %0d, want %0d", out_item.status, want.status));
        end
      end
    end
  end
endmodule

[dv/testbench.sv]
// Testbench top: drives conversions, applies backpressure and gives the verdict.
`timescale 1ns / 1ps
module testbench;
  import d2m_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count, pending;
  int   quiet_lo, quiet_hi, sent;

  d2m_if #(.payload_t(d2m_in_t))  in_ch ();
  d2m_if #(.payload_t(d2m_out_t)) out_ch ();

  double_to_mil1750a_float i_dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  d2m_checker i_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item(in_ch.payload),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_item(out_ch.payload),
    .fail_count(fail_count), .pending(pending)
  );

  always #5 clk = ~clk;

  // Idle about 7 times in 100, except inside the quiet window where the
  // sender and the receiver both run flat out.
  function automatic bit idle_now();
    if (sent >= quiet_lo && sent < quiet_hi) return 1'b0;
    return $urandom_range(99) < 7;
  endfunction

  // Receiver: drop ready at random.
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= !idle_now();
  end

  // Pick a double with interesting exponent: normal near the clamps, subnormal,
  // zero, special, an all-ones or all-zero fraction, or fully random bits.
  function automatic logic [63:0] pick_double();
    logic [63:0] d;
    d = {$urandom, $urandom};
    case ($urandom_range(9))
      0: d[62:52] = 11'h7FF;
      1: d[62:52] = 11'h000;
      2: d[62:0] = '0;
      3: d[62:52] = 11'(1022 + $urandom_range(40) - 20);
      4: d[62:52] = 11'(1022 + $urandom_range(270) - 135);
      5: d[51:0] = {$urandom_range(3) == 0 ? 52'hF_FFFF_FFFF_FFFF : 52'h0};
      default: ;
    endcase
    return d;
  endfunction

  // Hold the item until it transfers; leave valid high if another follows.
  task automatic send(logic [63:0] d, logic [1:0] fsel);
    while (idle_now()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= '{kind: 1'($urandom), double_bits: d, format_select: fsel};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  initial begin
    logic [63:0] directed[$];
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    sent = 0;
    quiet_lo = 300 + $urandom_range(200);
    quiet_hi = quiet_lo + 150;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zeros, one, minus one, halves, extremes, subnormals, specials,
    // rounding carry and the negative top-bits-11 shift.
    directed = '{64'h0000000000000000, 64'h8000000000000000, 64'h3FF0000000000000,
                 64'hBFF0000000000000, 64'h3FE0000000000000, 64'hBFE0000000000000,
                 64'h7FEFFFFFFFFFFFFF, 64'hFFEFFFFFFFFFFFFF, 64'h0000000000000001,
                 64'h800FFFFFFFFFFFFF, 64'h7FF0000000000000, 64'hFFF8000000000001,
                 64'h3FEFFFFFFFFFFFFF, 64'hBFEFFFFFFFFFFFFF, 64'h4000000000000000,
                 64'hC010000000000000, 64'h3FD5555555555555, 64'hFFFFFFFFFFFFFFFF};
    foreach (directed[i])
      for (int f = 0; f < 4; f++)
        if (f < 3 || i % 6 == 0) send(directed[i], 2'(f));

    repeat (950) send(pick_double(), 2'($urandom_range(15) == 0 ? 3 : $urandom_range(2)));
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("[double_to_mil1750a_float] OK");
    end else begin
      $display("[double_to_mil1750a_float] ERROR");
    end
    $finish;
  end

  // Hard stop well past the slowest plausible run.
  initial begin
    #2ms;
    $display("[double_to_mil1750a_float] ERROR");
    $finish;
  end
endmodule

[files.f]
hw/rtl/d2m_pkg.sv
hw/rtl/d2m_if.sv
hw/rtl/d2m_norm.sv
hw/rtl/double_to_mil1750a_float.sv
hw/rtl/d2m_checker.sv
dv/d2m_checker.sv
dv/testbench.sv
